/* rtl/wbez_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_pkg
// Shared types and constants of the waypoint bezier evaluator.
// ----------------------------------------------------------------------------
package wbez_pkg;

   localparam int WBEZ_MAX_WAYPOINTS = 256;
   localparam int WBEZ_COORD_BITS    = 8;
   localparam int WBEZ_QUEUE_DEPTH   = 4;

   // t is Q0.16 and may reach 1.0, so one integer bit on top
   localparam int T_FRAC = 16;
   localparam int T_W    = T_FRAC + 1;

   // configuration register indexes
   localparam logic [2:0] CSR_SECTION_COUNT = 3'd0;
   localparam logic [2:0] CSR_CURVE_MODE    = 3'd1;
   localparam logic [2:0] CSR_START_X       = 3'd2;
   localparam logic [2:0] CSR_START_Y       = 3'd3;
   localparam logic [2:0] CSR_PATH_LENGTH   = 3'd4;

   // action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic [7:0] section_count;
      logic [7:0] start_x;
      logic [7:0] start_y;
   } wbez_cfg_type;

   typedef struct packed {
      logic       load;
      logic       err;
      logic [3:0] use_start;
      logic [7:0] section;
   } wbez_ctl_type;

endpackage
`default_nettype wire

/* rtl/wbez_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface wbez_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] point_index;
   logic [7:0] coord_x;
   logic [7:0] coord_y;
   logic [7:0] section;
   modport source (output valid, action, point_index, coord_x, coord_y, section,
                   input ready);
   modport sink   (input valid, action, point_index, coord_x, coord_y, section,
                   output ready);
endinterface

interface wbez_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] curve_x;
   logic [15:0] curve_y;
   logic        query_error;
   modport source (output valid, curve_x, curve_y, query_error, input ready);
   modport sink   (input valid, curve_x, curve_y, query_error, output ready);
endinterface

interface wbez_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/waypoint_bezier_evaluator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_bezier_evaluator_core
// Waypoint path store with cubic bezier point evaluation in Q8.8.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  req_chan   in         action, point_index, coord_x, coord_y, section
//  rsp_chan   out        curve_x, curve_y, query_error (one per query)
//  csr_chan   in         index, data (register write, always ready)
//
//  one item per cycle while no result is held; a query's result passes the
//  queue, store read with first divider stage, 4 more divider stages,
//  4 curve stages and the output register.
//  loads write the store when they leave the queue and give no result.
//  synchronous reset resets settings, valid bits and queue, not the store.
//  a held result stalls the whole back part; the queue still takes items
//  until its 4 entries are full.
// ----------------------------------------------------------------------------
module waypoint_bezier_evaluator_core import wbez_pkg::*; #(
   parameter int MAX_WAYPOINTS = WBEZ_MAX_WAYPOINTS,
   parameter int COORD_BITS    = WBEZ_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   wbez_req_if.sink    req_chan,
   wbez_rsp_if.source  rsp_chan,
   wbez_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int QW = $bits(wbez_ctl_type) + 4 * AW + 2 * COORD_BITS;

   wbez_cfg_type             cfg;
   wbez_ctl_type             f_ctl, b_ctl;
   logic [3:0][AW-1:0]       f_addr, b_addr;
   logic [2*COORD_BITS-1:0]  f_wdata, b_wdata;
   logic                     push, pop, q_empty, q_full;
   logic [QW-1:0]            head;

   wbez_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .push     (push),
      .ctl      (f_ctl),
      .addr     (f_addr),
      .wdata    (f_wdata),
      .cfg      (cfg)
   );

   wbez_queue #(.WIDTH(QW), .DEPTH(WBEZ_QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_ctl, f_addr, f_wdata}),
      .pop       (pop),
      .head_data (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign {b_ctl, b_addr, b_wdata} = head;

   wbez_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (!q_empty),
      .q_ctl    (b_ctl),
      .q_addr   (b_addr),
      .q_wdata  (b_wdata),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

/* rtl/wbez_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_front
// Register file, request acceptance and control point classification.
// ----------------------------------------------------------------------------
module wbez_front import wbez_pkg::*; #(
   parameter int MAX_WAYPOINTS = WBEZ_MAX_WAYPOINTS,
   parameter int COORD_BITS    = WBEZ_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   wbez_req_if.sink                                req_chan,
   wbez_csr_if.sink                                csr_chan,
   input  logic                                    q_full,
   output logic                                    push,
   output wbez_ctl_type                            ctl,
   output logic [3:0][$clog2(MAX_WAYPOINTS)-1:0]   addr,
   output logic [2*COORD_BITS-1:0]                 wdata,
   output wbez_cfg_type                            cfg
);

   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int CW = ($clog2(MAX_WAYPOINTS + 1) > 9) ? $clog2(MAX_WAYPOINTS + 1) : 9;
   localparam logic [CW-1:0] LIMIT = CW'(MAX_WAYPOINTS);

   logic [7:0] section_count_ff;
   logic       curve_mode_ff;
   logic [7:0] start_x_ff;
   logic [7:0] start_y_ff;
   logic [8:0] path_length_ff;

   logic [CW-1:0]      len;
   logic [CW-1:0]      idx;
   logic [3:0][CW-1:0] sel;
   logic [3:0]         use_start;
   logic               err;
   logic [COORD_BITS-1:0] cx;
   logic [COORD_BITS-1:0] cy;

   always_ff @(posedge clock) begin
      if (reset) begin
         section_count_ff <= 8'd10;
         curve_mode_ff    <= 1'b1;
         start_x_ff       <= 8'd0;
         start_y_ff       <= 8'd0;
         path_length_ff   <= 9'd0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SECTION_COUNT: section_count_ff <= csr_chan.data[7:0];
            CSR_CURVE_MODE:    curve_mode_ff    <= csr_chan.data[0];
            CSR_START_X:       start_x_ff       <= csr_chan.data[7:0];
            CSR_START_Y:       start_y_ff       <= csr_chan.data[7:0];
            CSR_PATH_LENGTH:   path_length_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !q_full;

   assign cfg.section_count = section_count_ff;
   assign cfg.start_x       = start_x_ff;
   assign cfg.start_y       = start_y_ff;

   // effective path length is capped at the store depth
   assign len = (CW'(path_length_ff) > LIMIT) ? LIMIT : CW'(path_length_ff);
   assign idx = CW'(req_chan.point_index);

   always_comb begin
      use_start = 4'b0000;
      sel       = '0;
      if (!curve_mode_ff) begin
         if (idx == '0) begin
            use_start = 4'b0011;
            sel[2] = CW'(0);
            sel[3] = CW'(1);
         end else if (idx == CW'(1)) begin
            use_start = 4'b0001;
            sel[1] = CW'(0);
            sel[2] = CW'(1);
            sel[3] = CW'(2);
         end else if (idx + CW'(1) == len) begin
            sel[0] = idx - CW'(2);
            sel[1] = idx - CW'(1);
            sel[2] = idx;
            sel[3] = idx;
         end else begin
            sel[0] = idx - CW'(2);
            sel[1] = idx - CW'(1);
            sel[2] = idx;
            sel[3] = idx + CW'(1);
         end
      end else begin
         if (idx == '0) begin
            use_start = 4'b0001;
            sel[1] = CW'(0);
            sel[2] = CW'(0);
            sel[3] = CW'(1);
         end else if (idx + CW'(1) == len) begin
            sel[0] = idx - CW'(1);
            sel[1] = idx;
            sel[2] = idx;
            sel[3] = idx;
         end else begin
            sel[0] = idx - CW'(1);
            sel[1] = idx;
            sel[2] = idx;
            sel[3] = idx + CW'(1);
         end
      end
   end

   always_comb begin
      err = (section_count_ff == 8'd0) || (req_chan.section > section_count_ff)
            || (idx >= len);
      for (int k = 0; k < 4; k++) begin
         if (!use_start[k] && (sel[k] >= len)) err = 1'b1;
      end
   end

   assign cx = COORD_BITS'({{COORD_BITS{1'b0}}, req_chan.coord_x});
   assign cy = COORD_BITS'({{COORD_BITS{1'b0}}, req_chan.coord_y});

   always_comb begin
      ctl.load      = (req_chan.action == ACT_LOAD);
      ctl.err       = err;
      ctl.use_start = use_start;
      ctl.section   = req_chan.section;
      for (int k = 0; k < 4; k++) addr[k] = sel[k][AW-1:0];
      // a load writes through the first address lane
      if (req_chan.action == ACT_LOAD) addr[0] = idx[AW-1:0];
      wdata = {cx, cy};
   end

   // loads beyond the store are taken and dropped
   assign push = req_chan.valid && !q_full
                 && ((req_chan.action == ACT_QUERY) || (idx < LIMIT));

endmodule
`default_nettype wire

/* rtl/wbez_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module wbez_queue import wbez_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = WBEZ_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);

   localparam int QAW = $clog2(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QAW+1)'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= push_data;
   end

   assign head_data = data_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* rtl/wbez_axis.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_axis
// Four stage de casteljau evaluation of one coordinate, exact integers.
// ----------------------------------------------------------------------------
module wbez_axis import wbez_pkg::*; #(
   parameter int PW = 8
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [T_W-1:0]        t,
   input  logic [3:0][PW-1:0]    p,
   output logic [15:0]           result
);

   localparam int L1W = PW + T_FRAC;
   localparam int L2W = PW + 2 * T_FRAC;
   localparam int L3W = PW + 3 * T_FRAC;
   localparam int SPL = L2W / 2;
   localparam int HIW = L2W - SPL;
   localparam int RW  = L3W - 40;

   logic [T_W-1:0] u;
   logic [T_W-1:0] t1_ff, u1_ff, t2_ff, u2_ff;
   logic [2:0][L1W-1:0] l1_ff, l1_in;
   logic [1:0][L2W-1:0] l2_ff, l2_in;
   logic [T_W+SPL-1:0] pu_lo_ff, pt_lo_ff;
   logic [T_W+HIW-1:0] pu_hi_ff, pt_hi_ff;
   logic [L3W-1:0]     acc_ff, acc_in, hi_sum;
   logic [PW+T_W-1:0]  m1a [3], m1b [3];
   logic [L1W+T_W-1:0] m2a [2], m2b [2];
   logic [RW-1:0]      r;

   assign u = T_W'(1 << T_FRAC) - t;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         m1a[k] = u * p[k];
         m1b[k] = t * p[k+1];
         l1_in[k] = m1a[k][L1W-1:0] + m1b[k][L1W-1:0];
      end
      for (int k = 0; k < 2; k++) begin
         m2a[k] = u1_ff * l1_ff[k];
         m2b[k] = t1_ff * l1_ff[k+1];
         l2_in[k] = m2a[k][L2W-1:0] + m2b[k][L2W-1:0];
      end
   end

   // last level is split in halves to keep each multiplier narrow
   always_comb begin
      hi_sum = L3W'(pu_hi_ff) + L3W'(pt_hi_ff);
      acc_in = (hi_sum << SPL) + L3W'(pu_lo_ff) + L3W'(pt_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff    <= t;
         u1_ff    <= u;
         l1_ff    <= l1_in;
         t2_ff    <= t1_ff;
         u2_ff    <= u1_ff;
         l2_ff    <= l2_in;
         pu_lo_ff <= u2_ff * l2_ff[0][SPL-1:0];
         pu_hi_ff <= u2_ff * l2_ff[0][L2W-1:SPL];
         pt_lo_ff <= t2_ff * l2_ff[1][SPL-1:0];
         pt_hi_ff <= t2_ff * l2_ff[1][L2W-1:SPL];
         acc_ff   <= acc_in;
      end
   end

   assign r = acc_ff[L3W-1:40];
   assign result = (r > RW'(16'hFFFF)) ? 16'hFFFF : r[15:0];

endmodule
`default_nettype wire

/* rtl/wbez_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_back
// Waypoint store, pipelined t divider, curve evaluation and output register.
// ----------------------------------------------------------------------------
module wbez_back import wbez_pkg::*; #(
   parameter int MAX_WAYPOINTS = WBEZ_MAX_WAYPOINTS,
   parameter int COORD_BITS    = WBEZ_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wbez_cfg_type                            cfg,
   input  logic                                    q_valid,
   input  wbez_ctl_type                            q_ctl,
   input  logic [3:0][$clog2(MAX_WAYPOINTS)-1:0]   q_addr,
   input  logic [2*COORD_BITS-1:0]                 q_wdata,
   output logic                                    q_pop,
   wbez_rsp_if.source                              rsp_chan
);

   localparam int C        = COORD_BITS;
   localparam int PW       = (COORD_BITS > 8) ? COORD_BITS : 8;
   localparam int DIV_BITS = 4;
   localparam int LAST_DIV = T_FRAC / DIV_BITS + 1;
   localparam int PIPE     = LAST_DIV + 4;

   logic en;
   logic wr;
   logic is_query;

   logic [2*C-1:0] mem [4][MAX_WAYPOINTS];
   logic [2*C-1:0] rd_ff [4];

   logic [PIPE:1]       vld_ff, vld_in;
   logic [PIPE:1]       err_ff;
   logic [3:0]          us_ff;
   logic [7:0]          rem_ff [1:LAST_DIV];
   logic [7:0]          rem_in [1:LAST_DIV];
   logic [T_W-1:0]      q_ff   [1:LAST_DIV];
   logic [T_W-1:0]      q_in   [1:LAST_DIV];
   logic [3:0][PW-1:0]  px_ff  [2:LAST_DIV];
   logic [3:0][PW-1:0]  py_ff  [2:LAST_DIV];
   logic [3:0][PW-1:0]  px_sel, py_sel;

   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff, rsp_y_ff;
   logic        rsp_err_ff;
   logic [15:0] axis_x, axis_y;

   // whole back part advances unless a result is held
   assign en       = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop    = en && q_valid;
   assign wr       = q_pop && q_ctl.load;
   assign is_query = q_pop && !q_ctl.load;

   // one store copy per control point lane, all written together
   for (genvar b = 0; b < 4; b++) begin : g_bank
      always_ff @(posedge clock) begin
         if (wr) mem[b][q_addr[0]] <= q_wdata;
         if (en) rd_ff[b] <= mem[b][q_addr[b]];
      end
   end

   always_comb begin
      logic [7:0]     r;
      logic [8:0]     r9;
      logic [T_W-1:0] q;
      q = '0;
      q[T_FRAC] = (q_ctl.section >= cfg.section_count);
      q_in[1]   = q;
      rem_in[1] = q[T_FRAC] ? q_ctl.section - cfg.section_count : q_ctl.section;
      for (int s = 2; s <= LAST_DIV; s++) begin
         r = rem_ff[s-1];
         q = q_ff[s-1];
         for (int j = 0; j < DIV_BITS; j++) begin
            r9 = {r, 1'b0};
            if (r9 >= {1'b0, cfg.section_count}) begin
               r9 = r9 - {1'b0, cfg.section_count};
               q[T_FRAC - 1 - (s - 2) * DIV_BITS - j] = 1'b1;
            end
            r = r9[7:0];
         end
         rem_in[s] = r;
         q_in[s]   = q;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px_sel[k] = us_ff[k] ? PW'(cfg.start_x) : PW'(rd_ff[k][2*C-1:C]);
         py_sel[k] = us_ff[k] ? PW'(cfg.start_y) : PW'(rd_ff[k][C-1:0]);
      end
      vld_in = {vld_ff[PIPE-1:1], is_query};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff <= {err_ff[PIPE-1:1], q_ctl.err};
         us_ff  <= q_ctl.use_start;
         for (int s = 1; s <= LAST_DIV; s++) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
         end
         px_ff[2] <= px_sel;
         py_ff[2] <= py_sel;
         for (int s = 3; s <= LAST_DIV; s++) begin
            px_ff[s] <= px_ff[s-1];
            py_ff[s] <= py_ff[s-1];
         end
         rsp_x_ff   <= err_ff[PIPE] ? 16'd0 : axis_x;
         rsp_y_ff   <= err_ff[PIPE] ? 16'd0 : axis_y;
         rsp_err_ff <= err_ff[PIPE];
      end
   end

   wbez_axis #(.PW(PW)) u_axis_x (
      .clock  (clock),
      .en     (en),
      .t      (q_ff[LAST_DIV]),
      .p      (px_ff[LAST_DIV]),
      .result (axis_x)
   );

   wbez_axis #(.PW(PW)) u_axis_y (
      .clock  (clock),
      .en     (en),
      .t      (q_ff[LAST_DIV]),
      .p      (py_ff[LAST_DIV]),
      .result (axis_y)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.curve_x     = rsp_x_ff;
   assign rsp_chan.curve_y     = rsp_y_ff;
   assign rsp_chan.query_error = rsp_err_ff;

endmodule
`default_nettype wire

/* rtl/wbez_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_checker
// Port level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module wbez_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] curve_x,
   input logic [15:0] curve_y,
   input logic        query_error
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(curve_x) && $stable(curve_y)
                                  && $stable(query_error))
      else $error("response changed while stalled");

   a_err_zero: assert property (@(posedge clock)
      rsp_valid && query_error |-> curve_x == 16'd0 && curve_y == 16'd0)
      else $error("error result with non-zero coordinates");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

endmodule

bind waypoint_bezier_evaluator_core wbez_checker u_wbez_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .curve_x     (rsp_chan.curve_x),
   .curve_y     (rsp_chan.curve_y),
   .query_error (rsp_chan.query_error)
);
`default_nettype wire

/* tb/wbez_result_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wbez_result_checker
// Watches the request, response and register channels of the waypoint bezier
// evaluator, keeps its own path store and registers, and works out the curve
// point of every query. Each response is checked field by field against the
// oldest outstanding point.
// ----------------------------------------------------------------------------
module wbez_result_checker import wbez_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   wbez_req_if   req_chan,
   wbez_rsp_if   rsp_chan,
   wbez_csr_if   csr_chan,
   output int    fail_count,
   output int    pending,
   output int    points_checked,
   output int    error_points
);

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic        err;
   } curve_point_type;

   curve_point_type outstanding_points[$];

   logic [7:0] section_count;
   logic       curve_mode;
   logic [7:0] start_x;
   logic [7:0] start_y;
   logic [8:0] path_length;
   logic [7:0] path_x [WBEZ_MAX_WAYPOINTS];
   logic [7:0] path_y [WBEZ_MAX_WAYPOINTS];

   function automatic logic [15:0] blend(longint unsigned t, logic [7:0] c0, logic [7:0] c1,
                                         logic [7:0] c2, logic [7:0] c3);
      longint unsigned u;
      longint unsigned acc;
      longint unsigned r;
      u   = 64'd65536 - t;
      acc = u * u * u * c0 + 64'd3 * u * u * t * c1 + 64'd3 * u * t * t * c2
            + t * t * t * c3;
      r   = acc >> 40;
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   function automatic curve_point_type curve_point(logic [7:0] idx, logic [7:0] sec);
      curve_point_type  p;
      int               sel [4];
      logic [7:0]       cx [4];
      logic [7:0]       cy [4];
      int               len;
      int               i;
      logic             bad;
      longint unsigned  t;
      i   = idx;
      len = (path_length > WBEZ_MAX_WAYPOINTS) ? WBEZ_MAX_WAYPOINTS : path_length;
      bad = (section_count == 0) || (sec > section_count);
      // -1 selects the start position
      if (curve_mode == 1'b0) begin
         if (i == 0) sel = '{-1, -1, 0, 1};
         else if (i == 1) sel = '{-1, 0, 1, 2};
         else if (i + 1 == len) sel = '{i - 2, i - 1, i, i};
         else sel = '{i - 2, i - 1, i, i + 1};
      end else begin
         if (i == 0) sel = '{-1, 0, 0, 1};
         else if (i + 1 == len) sel = '{i - 1, i, i, i};
         else sel = '{i - 1, i, i, i + 1};
      end
      if (i >= len) bad = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (sel[k] < 0) begin
            cx[k] = start_x;
            cy[k] = start_y;
         end else if (sel[k] >= len) begin
            bad   = 1'b1;
            cx[k] = '0;
            cy[k] = '0;
         end else begin
            cx[k] = path_x[sel[k]];
            cy[k] = path_y[sel[k]];
         end
      end
      if (bad) begin
         p.x   = '0;
         p.y   = '0;
         p.err = 1'b1;
      end else begin
         t     = (longint'(sec) * 64'd65536) / section_count;
         p.x   = blend(t, cx[0], cx[1], cx[2], cx[3]);
         p.y   = blend(t, cy[0], cy[1], cy[2], cy[3]);
         p.err = 1'b0;
      end
      return p;
   endfunction

   always @(posedge clock) begin
      curve_point_type want;
      if (reset) begin
         section_count = 8'd10;
         curve_mode    = 1'b1;
         start_x       = '0;
         start_y       = '0;
         path_length   = '0;
         outstanding_points.delete();
         fail_count     <= 0;
         points_checked <= 0;
         error_points   <= 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_SECTION_COUNT: section_count = csr_chan.data[7:0];
               CSR_CURVE_MODE:    curve_mode    = csr_chan.data[0];
               CSR_START_X:       start_x       = csr_chan.data[7:0];
               CSR_START_Y:       start_y       = csr_chan.data[7:0];
               CSR_PATH_LENGTH:   path_length   = csr_chan.data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.action == ACT_LOAD) begin
               path_x[req_chan.point_index] = req_chan.coord_x;
               path_y[req_chan.point_index] = req_chan.coord_y;
            end else begin
               outstanding_points.insert(outstanding_points.size(),
                                         curve_point(req_chan.point_index,
                                                     req_chan.section));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (outstanding_points.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response x=%h y=%h err=%b", rsp_chan.curve_x,
                           rsp_chan.curve_y, rsp_chan.query_error);
               fail_count <= fail_count + 1;
            end else begin
               want = outstanding_points.pop_front();
               points_checked <= points_checked + 1;
               if (want.err) error_points <= error_points + 1;
               if (rsp_chan.curve_x !== want.x || rsp_chan.curve_y !== want.y ||
                   rsp_chan.query_error !== want.err) begin
                  if (fail_count < 10)
                     $display("mismatch: expected x=%h y=%h err=%b, got x=%h y=%h err=%b",
                              want.x, want.y, want.err, rsp_chan.curve_x,
                              rsp_chan.curve_y, rsp_chan.query_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= outstanding_points.size();
   end

endmodule
`default_nettype wire

/* tb/tb_waypoint_bezier_evaluator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_waypoint_bezier_evaluator_core
// Fills the whole waypoint store, runs directed queries over the start, end
// and out-of-range cases of both curve modes, then random phases of loads and
// queries under changing register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_waypoint_bezier_evaluator_core;
   import wbez_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES     = 10;
   localparam int PHASE_ITEMS = 107;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   gap_max   = 7;
   int   stall_max = 7;
   int   idle_cycles = 0;
   int   fail_count, pending, points_checked, error_points;
   int   phases_run = 0;

   wbez_req_if req_chan ();
   wbez_rsp_if rsp_chan ();
   wbez_csr_if csr_chan ();

   waypoint_bezier_evaluator_core uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   wbez_result_checker point_checker (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan),
      .fail_count(fail_count), .pending(pending),
      .points_checked(points_checked), .error_points(error_points)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_waypoint_bezier_evaluator_core: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_item(logic act, logic [7:0] idx, logic [7:0] x, logic [7:0] y,
                            logic [7:0] sec);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.point_index <= idx;
      req_chan.coord_x     <= x;
      req_chan.coord_y     <= y;
      req_chan.section     <= sec;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic query(logic [7:0] idx, logic [7:0] sec);
      send_item(ACT_QUERY, idx, $urandom, $urandom, sec);
   endtask

   // lets loads reach the store and all points drain before a register write
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [8:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_path(logic [7:0] sc, logic mode, logic [7:0] sx, logic [7:0] sy,
                           logic [8:0] len);
      write_reg(CSR_SECTION_COUNT, {1'b0, sc});
      write_reg(CSR_CURVE_MODE, {8'd0, mode});
      write_reg(CSR_START_X, {1'b0, sx});
      write_reg(CSR_START_Y, {1'b0, sy});
      write_reg(CSR_PATH_LENGTH, len);
   endtask

   // response side stalls on its own
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   initial begin
      logic [7:0] sc;
      logic [8:0] len;
      int         len_eff;
      logic [7:0] idx;
      logic [7:0] sec;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_LOAD;
      req_chan.point_index <= '0;
      req_chan.coord_x     <= '0;
      req_chan.coord_y     <= '0;
      req_chan.section     <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= CSR_SECTION_COUNT;
      csr_chan.data        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry is written before any query can read it
      send_item(ACT_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(ACT_LOAD, 8'd1, 8'hFF, 8'hFF, 8'd0);
      for (int k = 2; k < WBEZ_MAX_WAYPOINTS; k++)
         send_item(ACT_LOAD, k[7:0], $urandom, $urandom, $urandom);

      // reset settings: empty path, so every query fails
      query(8'd0, 8'd0);
      query(8'd5, 8'd10);
      settle();
      set_path(8'd10, 1'b0, 8'hFF, 8'd0, 9'd256);
      query(8'd0, 8'd0);
      query(8'd0, 8'd10);
      query(8'd1, 8'd5);
      query(8'd2, 8'd3);
      query(8'd255, 8'd10);
      query(8'd128, 8'd11);
      query(8'd7, 8'hFF);
      send_item(ACT_LOAD, 8'd255, 8'hFF, 8'h00, 8'd0);
      query(8'd254, 8'd7);
      settle();
      set_path(8'd255, 1'b1, 8'd0, 8'hFF, 9'd256);
      query(8'd0, 8'd0);
      query(8'd0, 8'd255);
      query(8'd255, 8'd128);
      query(8'd100, 8'd1);
      settle();
      set_path(8'd1, 1'b0, 8'd3, 8'd200, 9'd2);
      query(8'd1, 8'd1);
      query(8'd0, 8'd1);
      query(8'd2, 8'd0);
      settle();
      write_reg(CSR_PATH_LENGTH, 9'd1);
      query(8'd0, 8'd0);
      settle();
      write_reg(CSR_CURVE_MODE, 9'd1);
      query(8'd0, 8'd1);
      query(8'd0, 8'd2);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin sc = 8'd1;   len = 9'd256; end
            1: begin sc = 8'd255; len = 9'd511; end
            2: begin sc = 8'd0;   len = 9'd3;   end
            3: begin sc = $urandom_range(1, 16); len = 9'd1; end
            4: begin sc = $urandom_range(1, 16); len = 9'd2; end
            5: begin sc = $urandom_range(1, 255); len = 9'd0; end
            default: begin
               sc  = $urandom_range(1, 255);
               len = $urandom_range(0, 300);
            end
         endcase
         set_path(sc, p[0], (p == 1) ? 8'hFF : 8'($urandom), (p == 1) ? 8'hFF : 8'($urandom),
                  len);
         len_eff   = (len > WBEZ_MAX_WAYPOINTS) ? WBEZ_MAX_WAYPOINTS : len;
         gap_max   = (p == 6 || p == 7) ? 0 : 7;
         stall_max = (p == 7 || p == 8) ? 0 : 7;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
            end else begin
               if (len_eff > 0 && $urandom_range(0, 9) < 8)
                  idx = $urandom_range(0, len_eff - 1);
               else
                  idx = $urandom;
               if ($urandom_range(0, 9) < 8)
                  sec = $urandom_range(0, sc);
               else
                  sec = $urandom;
               query(idx, sec);
            end
         end
         phases_run++;
      end
      gap_max   = 7;
      stall_max = 7;
      settle();

      $display("checked %0d curve points (%0d error results) over %0d register phases",
               points_checked, error_points, phases_run);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_waypoint_bezier_evaluator_core: clean");
      end else begin
         $display("%0d points still outstanding", pending);
         $display("tb_waypoint_bezier_evaluator_core: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
